// File: hw/rtl/spdi_pkg.sv
// ----------------------------------------------------------------------------
// Slot priority interrupt dispatcher package
// Shared sizes, codes, word layouts and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spdi_pkg;

   localparam int SLOT_COUNT        = 3;
   localparam int HANDLERS_PER_SLOT = 4;
   localparam int ENTRY_COUNT       = SLOT_COUNT * HANDLERS_PER_SLOT;

   localparam int SLOT_W      = 3;
   localparam int HANDLER_W   = 16;
   localparam int ARG_W       = 16;
   localparam int PRIO_W      = 3;
   localparam int STATUS_W    = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int POS_W       = (HANDLERS_PER_SLOT > 1) ? $clog2(HANDLERS_PER_SLOT) : 1;

   typedef enum logic {
      ACT_REGISTER = 1'b0,
      ACT_DISPATCH = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      SRC_M32   = 2'd0,
      SRC_T1    = 2'd1,
      SRC_E1    = 2'd2,
      SRC_OTHER = 2'd3
   } source_kind_type;

   typedef enum logic [1:0] {
      KIND_REG  = 2'd0,
      KIND_CALL = 2'd1,
      KIND_NONE = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      REG_INSERTED = 2'd0,
      REG_PRESENT  = 2'd1,
      REG_REJECTED = 2'd2,
      REG_OVERFLOW = 2'd3
   } reg_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRIO_M32    = 2'd0,
      CSR_PRIO_FRAMER = 2'd1,
      CSR_PRIO_LOW    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REG_WALK,
      ST_DISP_SEL,
      ST_DISP_CALL
   } state_type;

   typedef struct packed {
      logic                 action;
      logic [SLOT_W-1:0]    slot;
      logic [HANDLER_W-1:0] handler_id;
      logic [1:0]           source_kind;
      logic [ARG_W-1:0]     handler_arg;
      logic [STATUS_W-1:0]  status_word;
   } req_word_type;

   typedef struct packed {
      logic [1:0]           result_kind;
      logic [1:0]           reg_code;
      logic [SLOT_W-1:0]    call_slot;
      logic [HANDLER_W-1:0] call_handler;
      logic [ARG_W-1:0]     call_arg;
      logic                 last;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic reg_step;
      logic sel_step;
      logic call_step;
      logic emit_none;
   } cmd_type;

   typedef struct packed {
      logic reg_done;
      logic pending_zero;
      logic best_empty;
      logic call_end;
      logic called;
      logic out_free;
   } stat_type;

   function automatic logic [IDX_W-1:0] entry_index(input logic [SLOT_W-1:0] slot,
                                                    input logic [POS_W-1:0]  pos);
      int sum;
      sum = int'(slot) * HANDLERS_PER_SLOT + int'(pos);
      return IDX_W'(sum);
   endfunction

endpackage

// File: hw/rtl/spdi_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one request word with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface spdi_req_if import spdi_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/spdi_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one response word with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface spdi_rsp_if import spdi_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/spdi_csr_if.sv
// ----------------------------------------------------------------------------
// Register write channel
// Carries a register index and write data with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface spdi_csr_if import spdi_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [PRIO_W-1:0]      wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: hw/rtl/spdi_ctrl.sv
// ----------------------------------------------------------------------------
// Dispatcher controller
// Sequences registration walks and dispatch passes over the datapath.
// ----------------------------------------------------------------------------
module spdi_ctrl import spdi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_action,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_action == ACT_DISPATCH) ? ST_DISP_SEL : ST_REG_WALK;
            end
         end
         ST_REG_WALK: begin
            if (stat.out_free) begin
               cmd.reg_step = 1'b1;
               if (stat.reg_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DISP_SEL: begin
            if (stat.pending_zero) begin
               if (stat.called) begin
                  state_in = ST_IDLE;
               end else if (stat.out_free) begin
                  cmd.emit_none = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.sel_step = 1'b1;
               if (!stat.best_empty) begin
                  state_in = ST_DISP_CALL;
               end
            end
         end
         ST_DISP_CALL: begin
            if (stat.out_free) begin
               cmd.call_step = 1'b1;
               if (stat.call_end) begin
                  state_in = ST_DISP_SEL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_call_follows_select: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DISP_CALL |->
         $past(state_ff) == ST_DISP_SEL || $past(state_ff) == ST_DISP_CALL)
      else $error("call phase entered without a slot selection");

   a_no_work_while_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.reg_step || cmd.sel_step || cmd.call_step || cmd.emit_none))
      else $error("datapath commanded while a new word is being taken");

endmodule

// File: hw/rtl/spdi_datapath.sv
// ----------------------------------------------------------------------------
// Dispatcher datapath
// Holds the priority registers, the handler lists, the word in progress and
// the response register.
// ----------------------------------------------------------------------------
module spdi_datapath import spdi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  req_word_type           req_data,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PRIO_W-1:0]      csr_wdata,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output rsp_word_type           rsp_data
);

   logic [PRIO_W-1:0]    prio_m32_ff, prio_m32_in;
   logic [PRIO_W-1:0]    prio_framer_ff, prio_framer_in;
   logic [PRIO_W-1:0]    prio_low_ff, prio_low_in;

   logic [HANDLER_W-1:0] entry_handler_ff [ENTRY_COUNT];
   logic [HANDLER_W-1:0] entry_handler_in [ENTRY_COUNT];
   logic [ARG_W-1:0]     entry_arg_ff [ENTRY_COUNT];
   logic [ARG_W-1:0]     entry_arg_in [ENTRY_COUNT];
   logic [PRIO_W-1:0]    entry_prio_ff [ENTRY_COUNT];
   logic [PRIO_W-1:0]    entry_prio_in [ENTRY_COUNT];

   logic                 action_ff, action_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [HANDLER_W-1:0] carry_handler_ff, carry_handler_in;
   logic [ARG_W-1:0]     carry_arg_ff, carry_arg_in;
   logic [PRIO_W-1:0]    carry_prio_ff, carry_prio_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [SLOT_COUNT-1:0] pending_ff, pending_in;
   logic [SLOT_W-1:0]    cur_slot_ff, cur_slot_in;
   logic                 called_ff, called_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_data_ff, rsp_data_in;

   logic [ENTRY_COUNT-1:0] occupied;
   logic [PRIO_W-1:0]    head_prio [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] head_busy;
   logic [PRIO_W-1:0]    src_prio;
   logic [SLOT_W-1:0]    rd_slot;
   logic [IDX_W-1:0]     rd_idx;
   logic [IDX_W-1:0]     next_idx;
   logic [HANDLER_W-1:0] rd_handler;
   logic [ARG_W-1:0]     rd_arg;
   logic [PRIO_W-1:0]    rd_prio;
   logic                 rd_empty;
   logic                 rd_match;
   logic                 reject;
   logic                 last_pos;
   logic [SLOT_W-1:0]    best_slot;
   logic [PRIO_W-1:0]    best_prio;
   logic                 best_found;
   logic [SLOT_COUNT-1:0] best_mask;
   logic                 more_after;
   logic                 lists_packed;
   logic                 rsp_load;
   reg_code_type         reg_code;

   always_comb begin
      for (int e = 0; e < ENTRY_COUNT; e++) begin
         occupied[e] = (entry_handler_ff[e] != '0);
      end
      for (int s = 0; s < SLOT_COUNT; s++) begin
         head_prio[s] = entry_prio_ff[entry_index(SLOT_W'(s), POS_W'(0))];
         head_busy[s] = occupied[entry_index(SLOT_W'(s), POS_W'(0))];
      end
      lists_packed = 1'b1;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         for (int j = 1; j < HANDLERS_PER_SLOT; j++) begin
            if (occupied[entry_index(SLOT_W'(s), POS_W'(j))] &&
                !occupied[entry_index(SLOT_W'(s), POS_W'(j - 1))]) begin
               lists_packed = 1'b0;
            end
         end
      end
   end

   always_comb begin
      if (req_data.source_kind == SRC_M32) begin
         src_prio = prio_m32_ff;
      end else if (req_data.source_kind inside {SRC_T1, SRC_E1}) begin
         src_prio = prio_framer_ff;
      end else begin
         src_prio = prio_low_ff;
      end
   end

   always_comb begin
      rd_slot    = action_ff ? cur_slot_ff : slot_ff;
      rd_idx     = entry_index(rd_slot, pos_ff);
      next_idx   = rd_idx + IDX_W'(1);
      rd_handler = entry_handler_ff[rd_idx];
      rd_arg     = entry_arg_ff[rd_idx];
      rd_prio    = entry_prio_ff[rd_idx];
      rd_empty   = !occupied[rd_idx];
      rd_match   = (rd_handler == carry_handler_ff);
      last_pos   = (pos_ff == POS_W'(HANDLERS_PER_SLOT - 1));
      reject     = ({1'b0, slot_ff} >= (SLOT_W + 1)'(SLOT_COUNT)) ||
                   (carry_handler_ff == '0);
      if (reject) begin
         reg_code = REG_REJECTED;
      end else if (rd_empty) begin
         reg_code = REG_INSERTED;
      end else if (rd_match) begin
         reg_code = REG_PRESENT;
      end else begin
         reg_code = REG_OVERFLOW;
      end
   end

   always_comb begin
      best_found = 1'b0;
      best_slot  = '0;
      best_prio  = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (pending_ff[s] && (!best_found || head_prio[s] > best_prio)) begin
            best_found = 1'b1;
            best_slot  = SLOT_W'(s);
            best_prio  = head_prio[s];
         end
      end
      for (int s = 0; s < SLOT_COUNT; s++) begin
         best_mask[s] = (SLOT_W'(s) == best_slot);
      end
      more_after = |(pending_ff & head_busy);
   end

   always_comb begin
      stat.reg_done     = reject || rd_empty || rd_match || last_pos;
      stat.pending_zero = (pending_ff == '0);
      stat.best_empty   = |(best_mask & ~head_busy);
      stat.call_end     = last_pos ? 1'b1 : !occupied[next_idx];
      stat.called       = called_ff;
      stat.out_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      prio_m32_in      = prio_m32_ff;
      prio_framer_in   = prio_framer_ff;
      prio_low_in      = prio_low_ff;
      entry_handler_in = entry_handler_ff;
      entry_arg_in     = entry_arg_ff;
      entry_prio_in    = entry_prio_ff;
      action_in        = action_ff;
      slot_in          = slot_ff;
      carry_handler_in = carry_handler_ff;
      carry_arg_in     = carry_arg_ff;
      carry_prio_in    = carry_prio_ff;
      pos_in           = pos_ff;
      pending_in       = pending_ff;
      cur_slot_in      = cur_slot_ff;
      called_in        = called_ff;
      rsp_load         = 1'b0;
      rsp_data_in      = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_PRIO_M32:    prio_m32_in = csr_wdata;
            CSR_PRIO_FRAMER: prio_framer_in = csr_wdata;
            CSR_PRIO_LOW:    prio_low_in = csr_wdata;
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         action_in        = req_data.action;
         slot_in          = req_data.slot;
         carry_handler_in = req_data.handler_id;
         carry_arg_in     = req_data.handler_arg;
         carry_prio_in    = src_prio;
         pos_in           = '0;
         pending_in       = ~req_data.status_word[SLOT_COUNT-1:0];
         called_in        = 1'b0;
      end

      if (cmd.reg_step) begin
         if (!reject) begin
            if (rd_empty || (!rd_match && rd_prio < carry_prio_ff)) begin
               entry_handler_in[rd_idx] = carry_handler_ff;
               entry_arg_in[rd_idx]     = carry_arg_ff;
               entry_prio_in[rd_idx]    = carry_prio_ff;
               carry_handler_in         = rd_handler;
               carry_arg_in             = rd_arg;
               carry_prio_in            = rd_prio;
            end
         end
         pos_in = pos_ff + POS_W'(1);
         if (stat.reg_done) begin
            rsp_load                 = 1'b1;
            rsp_data_in              = '0;
            rsp_data_in.result_kind  = KIND_REG;
            rsp_data_in.reg_code     = reg_code;
            rsp_data_in.last         = 1'b1;
         end
      end

      if (cmd.sel_step) begin
         pending_in  = pending_ff & ~best_mask;
         cur_slot_in = best_slot;
         pos_in      = '0;
      end

      if (cmd.call_step) begin
         rsp_load                 = 1'b1;
         rsp_data_in              = '0;
         rsp_data_in.result_kind  = KIND_CALL;
         rsp_data_in.call_slot    = cur_slot_ff;
         rsp_data_in.call_handler = rd_handler;
         rsp_data_in.call_arg     = rd_arg;
         rsp_data_in.last         = stat.call_end && !more_after;
         pos_in                   = pos_ff + POS_W'(1);
         called_in                = 1'b1;
      end

      if (cmd.emit_none) begin
         rsp_load                = 1'b1;
         rsp_data_in             = '0;
         rsp_data_in.result_kind = KIND_NONE;
         rsp_data_in.last        = 1'b1;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_m32_ff    <= PRIO_W'(3);
         prio_framer_ff <= PRIO_W'(2);
         prio_low_ff    <= PRIO_W'(1);
         for (int e = 0; e < ENTRY_COUNT; e++) begin
            entry_handler_ff[e] <= '0;
            entry_arg_ff[e]     <= '0;
            entry_prio_ff[e]    <= '0;
         end
         pending_ff   <= '0;
         called_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prio_m32_ff      <= prio_m32_in;
         prio_framer_ff   <= prio_framer_in;
         prio_low_ff      <= prio_low_in;
         entry_handler_ff <= entry_handler_in;
         entry_arg_ff     <= entry_arg_in;
         entry_prio_ff    <= entry_prio_in;
         pending_ff       <= pending_in;
         called_ff        <= called_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff        <= action_in;
      slot_ff          <= slot_in;
      carry_handler_ff <= carry_handler_in;
      carry_arg_ff     <= carry_arg_in;
      carry_prio_ff    <= carry_prio_in;
      pos_ff           <= pos_in;
      cur_slot_ff      <= cur_slot_in;
      rsp_data_ff      <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_lists_packed: assert property (@(posedge clock) disable iff (reset)
      lists_packed)
      else $error("handler list has a gap above an occupied entry");

   a_call_has_handler: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.result_kind == KIND_CALL |->
         rsp_data_ff.call_handler != '0)
      else $error("call word carries an empty handler");

   a_select_clears_one: assert property (@(posedge clock) disable iff (reset)
      cmd.sel_step && pending_ff != '0 |=>
         $countones(pending_ff) == $countones($past(pending_ff)) - 1)
      else $error("slot selection did not clear exactly one pending slot");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || rsp_ready)
      else $error("response register overwritten before it was taken");

endmodule

// File: hw/rtl/slot_priority_interrupt_dispatcher_top.sv
// ----------------------------------------------------------------------------
// Slot priority interrupt dispatcher
// Per-slot handler lists sorted by priority, with prioritised dispatch.
// ----------------------------------------------------------------------------
// A request word either registers a handler in its slot's list or dispatches
// the pending slots given by an active-low status word. Registration returns
// one outcome word. Dispatch returns one call word per handler of each
// pending slot, slots taken by falling head priority, or a single word saying
// that no handler was called; the last word of a request carries last.
// Register writes set the priority of each source kind and are taken at once.
// One request is worked on at a time. Registration takes the word and then
// walks the slot's list entry by entry until the walk ends. Dispatch takes
// the word, then makes a selection step for each pending slot, a step for
// each call word and a closing step, which sends the no-call word when no
// call was made. The response register lets selection steps go on while the
// previous word waits; when the receiver stalls, registration steps and the
// next word to be shown halt. Reset empties every list, restores the default
// priorities and drops any word in progress.
// ----------------------------------------------------------------------------
module slot_priority_interrupt_dispatcher_top import spdi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   spdi_req_if.sink   req_chan,
   spdi_rsp_if.source rsp_chan,
   spdi_csr_if.sink   csr_chan
);

   cmd_type      cmd;
   stat_type     stat;
   logic         req_ready;
   logic         rsp_valid;
   rsp_word_type rsp_data;

   spdi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.data.action),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   spdi_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_chan.data),
      .csr_valid (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_wdata (csr_chan.wdata),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.data  = rsp_data;

endmodule
